// ----- hw/rtl/smf_pkg.sv -----
// ----------------------------------------------------------------------------
// smf_pkg: shared types for the sliding window median filter
// Sample width, and the per-item command broadcast along the cell row.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned WLEN_W   = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Broadcast to every cell when an item is taken.
  typedef struct packed {
    logic    load;   // item accepted and window enabled
    logic    evict;  // window full: drop the oldest entry first
    sample_t value;  // incoming sample
  } cmd_t;

endpackage

// ----- hw/rtl/smf_sample_if.sv -----
// ----------------------------------------------------------------------------
// smf_sample_if: input item channel
// valid/ready handshake carrying one sample and its start-of-list flag.
// ----------------------------------------------------------------------------
interface smf_sample_if;
  import smf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    first_of_list;

  modport source (output valid, output sample, output first_of_list, input ready);
  modport sink   (input valid, input sample, input first_of_list, output ready);
endinterface

// ----- hw/rtl/smf_median_if.sv -----
// ----------------------------------------------------------------------------
// smf_median_if: result item channel
// valid/ready handshake carrying one median value.
// ----------------------------------------------------------------------------
interface smf_median_if;
  import smf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ----- hw/rtl/smf_cell.sv -----
// ----------------------------------------------------------------------------
// smf_cell: one slot of the sorted window
// Holds a value and its age; on each item it keeps, shifts in a neighbour
// or takes the new sample, so the row stays sorted after evict and insert.
// ----------------------------------------------------------------------------
module smf_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 7
) (
  input  logic              clk_i,
  input  smf_pkg::cmd_t     cmd_i,
  input  logic [CW-1:0]     fill_i,     // occupancy before this item
  input  logic [AW-1:0]     oldest_i,   // age of the entry to evict
  // neighbour below (lower index)
  input  smf_pkg::sample_t  lo_val_i,
  input  logic [AW-1:0]     lo_age_i,
  input  logic              lo_le_i,
  input  logic              pre_i,      // victim at or below the lower neighbour
  // neighbour above
  input  smf_pkg::sample_t  hi_val_i,
  input  logic [AW-1:0]     hi_age_i,
  input  logic              hi_le_i,
  output smf_pkg::sample_t  val_o,
  output logic [AW-1:0]     age_o,
  output logic              le_o,
  output logic              pre_o
);
  import smf_pkg::*;

  sample_t         val_q, val_d;
  logic [AW-1:0]   age_q, age_d;
  logic            valid, victim;
  logic            le_here, le_below;
  sample_t         keep_val, below_val;
  logic [AW-1:0]   keep_age, below_age;

  always_comb begin
    valid  = (CW'(INDEX) < fill_i);
    victim = cmd_i.evict & valid & (age_q == oldest_i);
    le_o   = valid & ~victim & (val_q <= cmd_i.value);
    pre_o  = pre_i | victim;

    // entry at this slot and the one below after the eviction closes the gap
    keep_val  = pre_o ? hi_val_i : val_q;
    keep_age  = pre_o ? hi_age_i : age_q;
    le_here   = pre_o ? hi_le_i  : le_o;
    below_val = pre_i ? val_q    : lo_val_i;
    below_age = pre_i ? age_q    : lo_age_i;
    le_below  = pre_i ? le_o     : lo_le_i;

    if (le_here) begin
      val_d = keep_val;
      age_d = keep_age + AW'(1);
    end else if (le_below) begin
      val_d = cmd_i.value;
      age_d = '0;
    end else begin
      val_d = below_val;
      age_d = below_age + AW'(1);
    end
  end

  // payload only; occupancy is tracked by the fill count
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule

// ----- hw/rtl/sliding_window_median_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_top: sliding window lower-median filter
// An item filling the window sets emit1_q; out_q then takes the median.
// One item per cycle unless med_o stalls; the cell row updates per item.
// Reset: window length 1, window empty, no result pending.
// A window length write empties the window.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [smf_pkg::WLEN_W-1:0]    cfg_wdata_i,
  smf_sample_if.sink                    smp_i,
  smf_median_if.source                  med_o
);
  import smf_pkg::*;

  localparam int unsigned N  = MAX_WINDOW;
  localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = $clog2(N + 1);

  logic [CW-1:0]  k_q, fill_q, fill_d;
  logic [AW-1:0]  mid_q;
  logic [CW-1:0]  k_new;
  logic [CW:0]    mid_wide;
  logic           emit1_q, emit1_d;
  logic           out_vq;
  sample_t        out_q, sel_val;

  logic           acc, adv, active, emit;
  logic [CW-1:0]  fill_eff, fill_new;
  cmd_t           cmd;

  sample_t        c_val [N];
  logic [AW-1:0]  c_age [N];
  logic           c_le  [N];
  logic           c_pre [N];

  // saturate the written length and find the median slot
  always_comb begin
    if (int'(cfg_wdata_i) > int'(N)) begin
      k_new = CW'(N);
    end else begin
      k_new = CW'(cfg_wdata_i);
    end
    mid_wide = (({1'b0, k_new} + (CW+1)'(1)) >> 1) - (CW+1)'(1);
  end

  always_comb begin
    adv      = ~out_vq | med_o.ready;
    acc      = smp_i.valid & smp_i.ready;
    active   = (k_q != '0);
    fill_eff = smp_i.first_of_list ? '0 : fill_q;
    cmd.evict = active & (fill_eff >= k_q);
    cmd.value = smp_i.sample;
    cmd.load  = acc & active;
    fill_new = fill_eff - CW'(cmd.evict) + CW'(1);
    emit     = active & (fill_new == k_q);

    fill_d = fill_q;
    if (cfg_we_i) begin
      fill_d = '0;
    end else if (cmd.load) begin
      fill_d = fill_new;
    end else if (acc && smp_i.first_of_list) begin
      fill_d = '0;
    end

    emit1_d = emit1_q;
    if (acc) begin
      emit1_d = emit;
    end else if (adv) begin
      emit1_d = 1'b0;
    end
  end

  assign smp_i.ready = ~emit1_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= CW'(1);
      mid_q   <= '0;
      fill_q  <= '0;
      emit1_q <= 1'b0;
      out_vq  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q   <= k_new;
        mid_q <= mid_wide[AW-1:0];
      end
      fill_q  <= fill_d;
      emit1_q <= emit1_d;
      if (adv) begin
        out_vq <= emit1_q;
      end
    end
  end

  // cell row
  for (genvar j = 0; j < N; j++) begin : g_cell
    sample_t       lo_val, hi_val;
    logic [AW-1:0] lo_age, hi_age;
    logic          lo_le, hi_le, pre_in;

    if (j == 0) begin : g_lo_edge
      assign lo_val = '0;
      assign lo_age = '0;
      assign lo_le  = 1'b1;
      assign pre_in = 1'b0;
    end else begin : g_lo
      assign lo_val = c_val[j-1];
      assign lo_age = c_age[j-1];
      assign lo_le  = c_le[j-1];
      assign pre_in = c_pre[j-1];
    end

    if (j == N - 1) begin : g_hi_edge
      assign hi_val = '0;
      assign hi_age = '0;
      assign hi_le  = 1'b0;
    end else begin : g_hi
      assign hi_val = c_val[j+1];
      assign hi_age = c_age[j+1];
      assign hi_le  = c_le[j+1];
    end

    smf_cell #(
      .INDEX (j),
      .AW    (AW),
      .CW    (CW)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .fill_i   (fill_eff),
      .oldest_i (AW'(fill_eff - CW'(1))),
      .lo_val_i (lo_val),
      .lo_age_i (lo_age),
      .lo_le_i  (lo_le),
      .pre_i    (pre_in),
      .hi_val_i (hi_val),
      .hi_age_i (hi_age),
      .hi_le_i  (hi_le),
      .val_o    (c_val[j]),
      .age_o    (c_age[j]),
      .le_o     (c_le[j]),
      .pre_o    (c_pre[j])
    );
  end

  // pick the median slot (and-or select across the row)
  always_comb begin
    sel_val = '0;
    for (int unsigned j = 0; j < N; j++) begin
      if (AW'(j) == mid_q) begin
        sel_val = sel_val | c_val[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit1_q) begin
      out_q <= sel_val;
    end
  end

  assign med_o.valid  = out_vq;
  assign med_o.median = out_q;

endmodule
